// ----- hw/rtl/jwc_pkg.sv -----
// ----------------------------------------------------------------------------
// jwc_pkg
// Widths, constants and the per-jet record shared by the centroid block.
// ----------------------------------------------------------------------------
package jwc_pkg;

  localparam int MAX_MEMBERS = 256;
  localparam int LOG_MAX     = $clog2(MAX_MEMBERS);

  localparam int PT_W        = 16;
  localparam int ANG_W       = 12;
  localparam int CNT_W       = $clog2(MAX_MEMBERS + 1);
  localparam int PROD_W      = PT_W + 1 + ANG_W;
  localparam int OUT_PT_W    = 24;
  localparam int OUT_CNT_W   = 9;
  localparam int PT_SUM_W    = (PT_W + LOG_MAX > OUT_PT_W) ? PT_W + LOG_MAX : OUT_PT_W;
  localparam int ANG_SUM_W   = ANG_W + LOG_MAX;
  localparam int PROD_SUM_W  = PROD_W + LOG_MAX;

  // divider sizing: every quotient is a mean of 12-bit values
  localparam int QW          = ANG_W;
  localparam int DV_W        = PROD_SUM_W;
  localparam int DS_W        = PT_SUM_W;
  localparam int DIV_STEP_W  = $clog2(QW + 1);

  localparam logic [OUT_PT_W-1:0] PT_TOTAL_MAX = '1;

  localparam int Q_DEPTH     = 2;
  localparam int QP_W        = $clog2(Q_DEPTH);
  localparam int QC_W        = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic        [PT_SUM_W-1:0]   pt_sum;
    logic        [CNT_W-1:0]      cnt;
    logic signed [ANG_SUM_W-1:0]  eta_sum;
    logic signed [PROD_SUM_W-1:0] pt_eta_sum;
    logic signed [ANG_SUM_W-1:0]  dphi_sum;
    logic signed [PROD_SUM_W-1:0] pt_dphi_sum;
    logic signed [ANG_W-1:0]      first_phi;
    logic                         dropped;
  } jet_rec_t;

endpackage

// ----- hw/rtl/jwc_front.sv -----
// ----------------------------------------------------------------------------
// jwc_front
// Takes constituents, forms phi offsets and products, accumulates per jet and
// hands a finished jet record to the queue.
// ----------------------------------------------------------------------------
module jwc_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              item_valid,
  output logic                              item_ready,
  input  logic [jwc_pkg::PT_W-1:0]          pt,
  input  logic signed [jwc_pkg::ANG_W-1:0]  eta,
  input  logic signed [jwc_pkg::ANG_W-1:0]  phi,
  input  logic                              last,
  input  logic                              full,
  output logic                              push,
  output jwc_pkg::jet_rec_t                 rec
);

  logic                                  in_jet;
  logic signed [jwc_pkg::ANG_W-1:0]      first_phi;
  logic signed [jwc_pkg::ANG_W-1:0]      dphi;
  logic signed [jwc_pkg::PROD_W-1:0]     pe_prod;
  logic signed [jwc_pkg::PROD_W-1:0]     pd_prod;
  logic                                  take_in;

  logic                                  a_valid;
  logic                                  a_last;
  logic [jwc_pkg::PT_W-1:0]              a_pt;
  logic signed [jwc_pkg::ANG_W-1:0]      a_eta;
  logic signed [jwc_pkg::ANG_W-1:0]      a_dphi;
  logic signed [jwc_pkg::ANG_W-1:0]      a_fp;
  logic signed [jwc_pkg::PROD_W-1:0]     a_pe;
  logic signed [jwc_pkg::PROD_W-1:0]     a_pd;
  logic                                  a_fire;

  logic [jwc_pkg::PT_SUM_W-1:0]          pt_acc, pt_acc_next;
  logic [jwc_pkg::CNT_W-1:0]             count_acc, count_acc_next;
  logic signed [jwc_pkg::ANG_SUM_W-1:0]  eta_acc, eta_acc_next;
  logic signed [jwc_pkg::PROD_SUM_W-1:0] pt_eta_acc, pt_eta_acc_next;
  logic signed [jwc_pkg::ANG_SUM_W-1:0]  dphi_acc, dphi_acc_next;
  logic signed [jwc_pkg::PROD_SUM_W-1:0] pt_dphi_acc, pt_dphi_acc_next;
  logic                                  drop_flag, drop_flag_next;
  logic                                  take;

  // offset from the first constituent wraps naturally in 12 bits
  assign dphi    = in_jet ? phi - first_phi : '0;
  assign pe_prod = $signed({1'b0, pt}) * eta;
  assign pd_prod = $signed({1'b0, pt}) * dphi;

  // a last item may only leave once the queue has room for its record
  assign a_fire     = a_valid && (!a_last || !full);
  assign item_ready = !a_valid || a_fire;
  assign take_in    = item_valid && item_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      in_jet  <= 1'b0;
    end else if (take_in) begin
      a_valid <= 1'b1;
      in_jet  <= !last;
    end else if (a_fire) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_in) begin
      if (!in_jet) begin
        first_phi <= phi;
      end
      a_last <= last;
      a_pt   <= pt;
      a_eta  <= eta;
      a_dphi <= dphi;
      a_fp   <= in_jet ? first_phi : phi;
      a_pe   <= pe_prod;
      a_pd   <= pd_prod;
    end
  end

  assign take = count_acc < jwc_pkg::CNT_W'(jwc_pkg::MAX_MEMBERS);

  always_comb begin
    pt_acc_next      = pt_acc;
    count_acc_next   = count_acc;
    eta_acc_next     = eta_acc;
    pt_eta_acc_next  = pt_eta_acc;
    dphi_acc_next    = dphi_acc;
    pt_dphi_acc_next = pt_dphi_acc;
    drop_flag_next   = drop_flag;
    if (take) begin
      pt_acc_next      = pt_acc + jwc_pkg::PT_SUM_W'(a_pt);
      count_acc_next   = count_acc + 1'b1;
      eta_acc_next     = eta_acc + jwc_pkg::ANG_SUM_W'(a_eta);
      pt_eta_acc_next  = pt_eta_acc + jwc_pkg::PROD_SUM_W'(a_pe);
      dphi_acc_next    = dphi_acc + jwc_pkg::ANG_SUM_W'(a_dphi);
      pt_dphi_acc_next = pt_dphi_acc + jwc_pkg::PROD_SUM_W'(a_pd);
    end else begin
      drop_flag_next   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (a_fire && a_last)) begin
      pt_acc      <= '0;
      count_acc   <= '0;
      eta_acc     <= '0;
      pt_eta_acc  <= '0;
      dphi_acc    <= '0;
      pt_dphi_acc <= '0;
      drop_flag   <= 1'b0;
    end else if (a_fire) begin
      pt_acc      <= pt_acc_next;
      count_acc   <= count_acc_next;
      eta_acc     <= eta_acc_next;
      pt_eta_acc  <= pt_eta_acc_next;
      dphi_acc    <= dphi_acc_next;
      pt_dphi_acc <= pt_dphi_acc_next;
      drop_flag   <= drop_flag_next;
    end
  end

  assign push = a_fire && a_last;

  always_comb begin
    rec.pt_sum      = pt_acc_next;
    rec.cnt         = count_acc_next;
    rec.eta_sum     = eta_acc_next;
    rec.pt_eta_sum  = pt_eta_acc_next;
    rec.dphi_sum    = dphi_acc_next;
    rec.pt_dphi_sum = pt_dphi_acc_next;
    rec.first_phi   = a_fp;
    rec.dropped     = drop_flag_next;
  end

endmodule

// ----- hw/rtl/jwc_queue.sv -----
// ----------------------------------------------------------------------------
// jwc_queue
// Short queue of finished jet records between accumulation and division.
// ----------------------------------------------------------------------------
module jwc_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  jwc_pkg::jet_rec_t wr_rec,
  output logic              full,
  output logic              valid,
  input  logic              pop,
  output jwc_pkg::jet_rec_t rd_rec
);

  jwc_pkg::jet_rec_t          store [jwc_pkg::Q_DEPTH];
  logic [jwc_pkg::QP_W-1:0]   wr_ptr;
  logic [jwc_pkg::QP_W-1:0]   rd_ptr;
  logic [jwc_pkg::QC_W-1:0]   fill;
  logic                       do_push;
  logic                       do_pop;

  assign full    = fill == jwc_pkg::QC_W'(jwc_pkg::Q_DEPTH);
  assign valid   = fill != '0;
  assign do_push = push && !full;
  assign do_pop  = pop && valid;
  assign rd_rec  = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == jwc_pkg::QP_W'(jwc_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == jwc_pkg::QP_W'(jwc_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= wr_rec;
    end
  end

endmodule

// ----- hw/rtl/jwc_div.sv -----
// ----------------------------------------------------------------------------
// jwc_div
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// The quotient magnitude is known to fit in QW bits.
// ----------------------------------------------------------------------------
module jwc_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic signed [jwc_pkg::DV_W-1:0]  dividend,
  input  logic [jwc_pkg::DS_W-1:0]         divisor,
  output logic                             busy,
  output logic signed [jwc_pkg::QW-1:0]    quotient
);

  logic [jwc_pkg::DIV_STEP_W-1:0] steps;
  logic                       neg;
  logic [jwc_pkg::DV_W-1:0]   mag;
  logic [jwc_pkg::DS_W-1:0]   dsr;
  logic [jwc_pkg::DS_W-1:0]   rem;
  logic [jwc_pkg::QW-1:0]     low;
  logic [jwc_pkg::QW-1:0]     q;
  logic [jwc_pkg::DS_W:0]     shifted;
  logic [jwc_pkg::DS_W:0]     diff;

  assign mag     = dividend[jwc_pkg::DV_W-1] ? jwc_pkg::DV_W'(-dividend) : dividend;
  assign shifted = {rem, low[jwc_pkg::QW-1]};
  assign diff    = shifted - {1'b0, dsr};
  assign busy    = steps != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      steps <= jwc_pkg::DIV_STEP_W'(jwc_pkg::QW);
    end else if (busy) begin
      steps <= steps - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[jwc_pkg::DV_W-1];
      dsr <= divisor;
      // upper part is below the divisor since the quotient fits in QW bits
      rem <= jwc_pkg::DS_W'(mag >> jwc_pkg::QW);
      low <= mag[jwc_pkg::QW-1:0];
      q   <= '0;
    end else if (busy) begin
      low <= {low[jwc_pkg::QW-2:0], 1'b0};
      if (!diff[jwc_pkg::DS_W]) begin
        rem <= diff[jwc_pkg::DS_W-1:0];
        q   <= {q[jwc_pkg::QW-2:0], 1'b1};
      end else begin
        rem <= shifted[jwc_pkg::DS_W-1:0];
        q   <= {q[jwc_pkg::QW-2:0], 1'b0};
      end
    end
  end

  assign quotient = neg ? -$signed(q) : $signed(q);

endmodule

// ----- hw/rtl/jwc_back.sv -----
// ----------------------------------------------------------------------------
// jwc_back
// Pops jet records, runs the four divisions side by side and holds the
// result in an output register.
// ----------------------------------------------------------------------------
module jwc_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  valid,
  input  jwc_pkg::jet_rec_t                     rec,
  output logic                                  pop,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [jwc_pkg::OUT_PT_W-1:0]          pt_total,
  output logic signed [jwc_pkg::ANG_W-1:0]      weighted_eta,
  output logic signed [jwc_pkg::ANG_W-1:0]      weighted_phi,
  output logic signed [jwc_pkg::ANG_W-1:0]      mean_eta,
  output logic signed [jwc_pkg::ANG_W-1:0]      mean_phi,
  output logic [jwc_pkg::OUT_CNT_W-1:0]         member_count,
  output logic                                  zero_pt,
  output logic                                  overflowed
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_HOLD = 3'b100
  } back_state_t;

  back_state_t                       state, state_next;
  logic                              start;
  logic                              load;
  logic                              out_free;
  logic                              busy_any;
  logic [3:0]                        busy;
  logic signed [jwc_pkg::ANG_W-1:0]  q_weta, q_wphi, q_meta, q_mphi;

  logic signed [jwc_pkg::ANG_W-1:0]  fp;
  logic [jwc_pkg::OUT_PT_W-1:0]      pt_sat;
  logic [jwc_pkg::OUT_CNT_W-1:0]     cnt;
  logic                              zero;
  logic                              drop;

  logic [jwc_pkg::DS_W-1:0]          cnt_div;

  assign cnt_div  = jwc_pkg::DS_W'(rec.cnt);
  assign busy_any = |busy;
  assign out_free = !out_valid || out_ready;
  assign start    = (state == S_IDLE) && valid;
  assign pop      = start;

  jwc_div u_div_weta (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .dividend (rec.pt_eta_sum),
    .divisor  (rec.pt_sum),
    .busy     (busy[0]),
    .quotient (q_weta)
  );

  jwc_div u_div_wphi (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .dividend (rec.pt_dphi_sum),
    .divisor  (rec.pt_sum),
    .busy     (busy[1]),
    .quotient (q_wphi)
  );

  jwc_div u_div_meta (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .dividend (jwc_pkg::DV_W'(rec.eta_sum)),
    .divisor  (cnt_div),
    .busy     (busy[2]),
    .quotient (q_meta)
  );

  jwc_div u_div_mphi (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .dividend (jwc_pkg::DV_W'(rec.dphi_sum)),
    .divisor  (cnt_div),
    .busy     (busy[3]),
    .quotient (q_mphi)
  );

  always_comb begin
    state_next = state;
    load       = 1'b0;
    case (state)
      S_IDLE: begin
        if (valid) begin
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (!busy_any) begin
          if (out_free) begin
            load       = 1'b1;
            state_next = S_IDLE;
          end else begin
            state_next = S_HOLD;
          end
        end
      end
      S_HOLD: begin
        if (out_free) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // fields of the jet that the dividers do not need
  always_ff @(posedge clk) begin
    if (start) begin
      fp     <= rec.first_phi;
      pt_sat <= (rec.pt_sum > jwc_pkg::PT_SUM_W'(jwc_pkg::PT_TOTAL_MAX)) ?
                jwc_pkg::PT_TOTAL_MAX : jwc_pkg::OUT_PT_W'(rec.pt_sum);
      cnt    <= jwc_pkg::OUT_CNT_W'(rec.cnt);
      zero   <= rec.pt_sum == '0;
      drop   <= rec.dropped;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pt_total     <= pt_sat;
      weighted_eta <= zero ? '0 : q_weta;
      weighted_phi <= zero ? '0 : fp + q_wphi;
      mean_eta     <= q_meta;
      mean_phi     <= fp + q_mphi;
      member_count <= cnt;
      zero_pt      <= zero;
      overflowed   <= drop;
    end
  end

endmodule

// ----- hw/rtl/jet_weighted_centroid.sv -----
// path: input stage register, record queue, dividers, output register
// throughput: one constituent per cycle, one jet at a time in the dividers, and
// a two-deep record queue absorbs short jets before input stalls on a last item
// reset: synchronous rst clears accumulators, queue and output valid register
// ----------------------------------------------------------------------------
// jet_weighted_centroid
// pt-weighted and plain eta/phi centroid of each jet from a constituent stream.
// ----------------------------------------------------------------------------
module jet_weighted_centroid (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // pt[15:0], eta[27:16], phi[39:28]
  input  logic        s_tlast,   // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // pt_total[23:0], weighted_eta[35:24],
                                 // weighted_phi[47:36], mean_eta[59:48],
                                 // mean_phi[71:60], member_count[80:72], zero
  output logic [1:0]  m_tuser    // zero_pt[0], overflowed[1]
);

  jwc_pkg::jet_rec_t                 wr_rec;
  jwc_pkg::jet_rec_t                 rd_rec;
  logic                              q_push;
  logic                              q_full;
  logic                              q_valid;
  logic                              q_pop;

  logic [jwc_pkg::OUT_PT_W-1:0]      pt_total;
  logic signed [jwc_pkg::ANG_W-1:0]  weighted_eta;
  logic signed [jwc_pkg::ANG_W-1:0]  weighted_phi;
  logic signed [jwc_pkg::ANG_W-1:0]  mean_eta;
  logic signed [jwc_pkg::ANG_W-1:0]  mean_phi;
  logic [jwc_pkg::OUT_CNT_W-1:0]     member_count;
  logic                              zero_pt;
  logic                              overflowed;

  jwc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (s_tvalid),
    .item_ready (s_tready),
    .pt         (s_tdata[15:0]),
    .eta        ($signed(s_tdata[27:16])),
    .phi        ($signed(s_tdata[39:28])),
    .last       (s_tlast),
    .full       (q_full),
    .push       (q_push),
    .rec        (wr_rec)
  );

  jwc_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_rec (wr_rec),
    .full   (q_full),
    .valid  (q_valid),
    .pop    (q_pop),
    .rd_rec (rd_rec)
  );

  jwc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .valid        (q_valid),
    .rec          (rd_rec),
    .pop          (q_pop),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .pt_total     (pt_total),
    .weighted_eta (weighted_eta),
    .weighted_phi (weighted_phi),
    .mean_eta     (mean_eta),
    .mean_phi     (mean_phi),
    .member_count (member_count),
    .zero_pt      (zero_pt),
    .overflowed   (overflowed)
  );

  assign m_tdata = {7'd0, member_count, mean_phi, mean_eta,
                    weighted_phi, weighted_eta, pt_total};
  assign m_tuser = {overflowed, zero_pt};

  // a record is never pushed into a full queue
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("jet record pushed into full queue");

  // a zero pt sum leaves the weighted fields at zero
  a_zero_weighted: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata[47:24] == 24'd0))
    else $error("weighted fields non-zero with zero pt sum");

  // dropping only happens once the jet is full
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[1]) |->
      (m_tdata[80:72] == jwc_pkg::OUT_CNT_W'(jwc_pkg::MAX_MEMBERS)))
    else $error("overflow flagged below the member limit");

  // the queue is only popped when it holds a record
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

endmodule
